// ===== src/pnrf_pkg.sv =====
// Shared types and codes for the packed-nibble rectangle fill engine.
package pnrf_pkg;

   localparam logic [1:0] ACT_FILL  = 2'd0;
   localparam logic [1:0] ACT_BOX   = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   localparam int JQ_DEPTH = 4;
   localparam int JQ_PTR_W = 2;
   localparam int JQ_CNT_W = 3;

   typedef struct packed {
      logic [1:0] action;
      logic [9:0] x_left;
      logic [9:0] x_right;
      logic [9:0] y_top;
      logic [9:0] y_bottom;
      logic [3:0] color;
      logic [7:0] line_width;
   } req_type;

   typedef struct packed {
      logic [3:0] pixel_value;
      logic       in_range;
   } rsp_type;

   // One clipped rectangle (or one pixel read) for the back end.
   typedef struct packed {
      logic        is_read;
      logic        read_ok;
      logic        last;
      logic [3:0]  color;
      logic [9:0]  x0;
      logic [10:0] x1;
      logic [9:0]  y0;
      logic [10:0] y1;
   } job_type;

endpackage

// ===== src/pnrf_front.sv =====
// Front end: accept requests and break them into clipped rectangle jobs.
module pnrf_front #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  pnrf_pkg::req_type req_payload,
   input  logic [3:0]       background_color,
   output logic             job_push,
   input  logic             job_full,
   output pnrf_pkg::job_type job_data
);

   localparam logic [10:0] W_LIM = 11'(SCREEN_WIDTH);
   localparam logic [10:0] H_LIM = 11'(SCREEN_HEIGHT);

   localparam logic [1:0] BAND_TOP    = 2'd0;
   localparam logic [1:0] BAND_BOTTOM = 2'd1;
   localparam logic [1:0] BAND_LEFT   = 2'd2;
   localparam logic [1:0] BAND_RIGHT  = 2'd3;

   logic              busy_ff, busy_in;
   logic [1:0]        phase_ff, phase_in;
   pnrf_pkg::req_type cmd_ff, cmd_in;

   logic [10:0] xl_e, xr_e, yt_e, yb_e, w_e;

   function automatic logic [10:0] clip_val(input logic [10:0] v, input logic [10:0] lim);
      return (v < lim) ? v : lim;
   endfunction

   assign xl_e = {1'b0, cmd_ff.x_left};
   assign xr_e = {1'b0, cmd_ff.x_right};
   assign yt_e = {1'b0, cmd_ff.y_top};
   assign yb_e = {1'b0, cmd_ff.y_bottom};
   assign w_e  = {3'b000, cmd_ff.line_width};

   always_comb begin
      job_data         = '0;
      job_data.color   = cmd_ff.color;
      job_data.last    = 1'b1;
      unique case (cmd_ff.action)
         pnrf_pkg::ACT_FILL: begin
            job_data.x0 = cmd_ff.x_left;
            job_data.x1 = clip_val(xr_e, W_LIM);
            job_data.y0 = cmd_ff.y_top;
            job_data.y1 = clip_val(yb_e, H_LIM);
         end
         pnrf_pkg::ACT_BOX: begin
            job_data.last = (phase_ff == BAND_RIGHT);
            unique case (phase_ff)
               BAND_TOP: begin
                  job_data.x0 = cmd_ff.x_left;
                  job_data.x1 = clip_val(xr_e, W_LIM);
                  job_data.y0 = cmd_ff.y_top;
                  job_data.y1 = clip_val(yt_e + w_e, H_LIM);
               end
               BAND_BOTTOM: begin
                  job_data.x0 = cmd_ff.x_left;
                  job_data.x1 = clip_val(xr_e, W_LIM);
                  job_data.y0 = cmd_ff.y_bottom;
                  job_data.y1 = clip_val(yb_e + w_e, H_LIM);
               end
               BAND_LEFT: begin
                  job_data.x0 = cmd_ff.x_left;
                  job_data.x1 = clip_val(xl_e + w_e, W_LIM);
                  job_data.y0 = cmd_ff.y_top;
                  job_data.y1 = clip_val(yb_e, H_LIM);
               end
               BAND_RIGHT: begin
                  // right edge runs down past the bottom by the line width
                  job_data.x0 = cmd_ff.x_right;
                  job_data.x1 = clip_val(xr_e + w_e, W_LIM);
                  job_data.y0 = cmd_ff.y_top;
                  job_data.y1 = clip_val(yb_e + w_e, H_LIM);
               end
            endcase
         end
         pnrf_pkg::ACT_CLEAR: begin
            job_data.x0 = '0;
            job_data.x1 = W_LIM;
            job_data.y0 = '0;
            job_data.y1 = H_LIM;
         end
         pnrf_pkg::ACT_READ: begin
            job_data.is_read = 1'b1;
            job_data.read_ok = (xl_e < W_LIM) && (yt_e < H_LIM);
            job_data.x0      = cmd_ff.x_left;
            job_data.y0      = cmd_ff.y_top;
         end
      endcase
   end

   assign req_full = busy_ff;
   assign job_push = busy_ff && !job_full;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      if (job_push) begin
         if (job_data.last) begin
            busy_in = 1'b0;
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
      if (req_push && !busy_ff) begin
         busy_in  = 1'b1;
         phase_in = BAND_TOP;
         cmd_in   = req_payload;
         // latch the clear color now; it cannot change while a request is open
         if (req_payload.action == pnrf_pkg::ACT_CLEAR) begin
            cmd_in.color = background_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= BAND_TOP;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// ===== src/pnrf_job_queue.sv =====
// Short job queue between the front end and the back end.
module pnrf_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  pnrf_pkg::job_type push_data,
   input  logic             pop,
   output logic             empty,
   output pnrf_pkg::job_type pop_data
);

   pnrf_pkg::job_type                 slot_ff [pnrf_pkg::JQ_DEPTH];
   logic [pnrf_pkg::JQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pnrf_pkg::JQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pnrf_pkg::JQ_CNT_W-1:0]     count_ff, count_in;
   logic                              do_push, do_pop;

   assign full     = (count_ff == pnrf_pkg::JQ_CNT_W'(pnrf_pkg::JQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (do_push ? pnrf_pkg::JQ_PTR_W'(1) : pnrf_pkg::JQ_PTR_W'(0));
      rd_ptr_in = rd_ptr_ff + (do_pop ? pnrf_pkg::JQ_PTR_W'(1) : pnrf_pkg::JQ_PTR_W'(0));
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + pnrf_pkg::JQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - pnrf_pkg::JQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/pnrf_back.sv =====
// Back end: walk each job byte by byte over the frame store and post results.
module pnrf_back #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   output logic             job_pop,
   input  pnrf_pkg::job_type job_head,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pnrf_pkg::rsp_type rsp_payload
);

   localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_SETUP  = 3'd1;
   localparam logic [2:0] B_WALK   = 3'd2;
   localparam logic [2:0] B_MODIFY = 3'd3;
   localparam logic [2:0] B_RDADDR = 3'd4;
   localparam logic [2:0] B_RDDATA = 3'd5;
   localparam logic [2:0] B_DONE   = 3'd6;

   logic [2:0]        state_ff, state_in;
   pnrf_pkg::job_type job_ff, job_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [9:0]        y_ff, y_in;
   logic [8:0]        bx_ff, bx_in;
   logic [8:0]        last_bx_ff, last_bx_in;
   logic [3:0]        pv_ff, pv_in;
   logic              ok_ff, ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pnrf_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]        frame_mem [STORE_BYTES];
   logic [7:0]        rd_byte_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        mem_wdata;

   logic [19:0]       row_prod;
   logic [10:0]       x1_m1;
   logic [10:0]       px_even, px_odd;
   logic              hi_cov, lo_cov;
   logic              row_end, job_end;

   assign row_prod = {10'b0, job_ff.y0} * 20'(ROW_BYTES);
   assign x1_m1    = job_ff.x1 - 11'd1;
   assign px_even  = {1'b0, bx_ff, 1'b0};
   assign px_odd   = {1'b0, bx_ff, 1'b1};
   assign hi_cov   = (px_even >= {1'b0, job_ff.x0}) && (px_even < job_ff.x1);
   assign lo_cov   = (px_odd  >= {1'b0, job_ff.x0}) && (px_odd  < job_ff.x1);
   assign row_end  = (bx_ff == last_bx_ff);
   assign job_end  = row_end && (({1'b0, y_ff} + 11'd1) == job_ff.y1);
   assign mem_addr = row_base_ff + ADDR_W'(bx_ff);

   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign job_pop     = (state_ff == B_IDLE) && !job_empty;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      row_base_in  = row_base_ff;
      y_in         = y_ff;
      bx_in        = bx_ff;
      last_bx_in   = last_bx_ff;
      pv_in        = pv_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wdata    = {job_ff.color, job_ff.color};
      unique case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_in   = job_head;
               state_in = B_SETUP;
            end
         end
         B_SETUP: begin
            row_base_in = row_prod[ADDR_W-1:0];
            y_in        = job_ff.y0;
            bx_in       = job_ff.x0[9:1];
            last_bx_in  = x1_m1[9:1];
            pv_in       = 4'd0;
            ok_in       = job_ff.is_read && job_ff.read_ok;
            if (job_ff.is_read) begin
               state_in = job_ff.read_ok ? B_RDADDR : B_DONE;
            end else if (({1'b0, job_ff.x0} >= job_ff.x1) ||
                         ({1'b0, job_ff.y0} >= job_ff.y1)) begin
               state_in = B_DONE;
            end else begin
               state_in = B_WALK;
            end
         end
         B_WALK, B_MODIFY: begin
            // a byte with both nibbles covered needs no read first
            if ((state_ff == B_WALK) && !(hi_cov && lo_cov)) begin
               state_in = B_MODIFY;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = {hi_cov ? job_ff.color : rd_byte_ff[7:4],
                            lo_cov ? job_ff.color : rd_byte_ff[3:0]};
               state_in  = B_WALK;
               if (job_end) begin
                  state_in = B_DONE;
               end else if (row_end) begin
                  y_in        = y_ff + 10'd1;
                  bx_in       = job_ff.x0[9:1];
                  row_base_in = row_base_ff + ADDR_W'(ROW_BYTES);
               end else begin
                  bx_in = bx_ff + 9'd1;
               end
            end
         end
         B_RDADDR: begin
            state_in = B_RDDATA;
         end
         B_RDDATA: begin
            pv_in    = job_ff.x0[0] ? rd_byte_ff[3:0] : rd_byte_ff[7:4];
            state_in = B_DONE;
         end
         B_DONE: begin
            if (!job_ff.last) begin
               state_in = B_IDLE;
            end else if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in       = 1'b1;
               rsp_in.pixel_value = pv_ff;
               rsp_in.in_range    = ok_ff;
               state_in           = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff      <= job_in;
      row_base_ff <= row_base_in;
      y_ff        <= y_in;
      bx_ff       <= bx_in;
      last_bx_ff  <= last_bx_in;
      pv_ff       <= pv_in;
      ok_ff       <= ok_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= mem_wdata;
      end
      rd_byte_ff <= frame_mem[mem_addr];
   end

endmodule

// ===== src/packed_nibble_rect_fill_engine.sv =====
// Top level of the packed-nibble rectangle fill engine.
//
// Drawing engine over a 4-bit-per-pixel frame store, two pixels a byte, even
// column in the high nibble. Requests enter on req_push/req_full (accepted
// when push is high and full is low) and carry fill, box, clear or read.
// Every request gives exactly one response on rsp_empty/rsp_pop: the pixel
// and on-screen flag for a read, zeros for the drawing requests.
// csr_valid/csr_ready writes the background color used by clear; it is
// always ready. The user must write it only while the engine is idle; the
// block itself does not enforce it. The front end turns a request into one
// rectangle job (four for a box) at one job a cycle while the job queue is
// not full and pushes it into a four-entry job queue; the back end walks
// each job over the single-port frame store. A byte whose nibbles are both
// covered is written at once, an edge byte is read, then merge-written.
// Each job passes a setup state first; a read then has an address state and
// a data state, and a clear walks every byte of the frame store.
// The front end accepts the next request as soon as the last job of the
// current one is queued, so requests overlap with the walk of earlier ones.
// Reset clears the control state and the background color; frame store
// contents are undefined until drawn. A stalled receiver holds the response
// register and backs up the back end, then the queue, then req_full.
module packed_nibble_rect_fill_engine #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  pnrf_pkg::req_type req_payload,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pnrf_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_data
);

   logic [3:0]        background_color_ff, background_color_in;
   logic              job_push, job_full, job_pop, job_empty;
   pnrf_pkg::job_type job_in_data, job_head;

   // Hold the background color until the next register write.
   assign csr_ready           = 1'b1;
   assign background_color_in = (csr_valid && csr_ready) ? csr_data : background_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         background_color_ff <= 4'd0;
      end else begin
         background_color_ff <= background_color_in;
      end
   end

   // Classify requests and split them into clipped rectangles.
   pnrf_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_payload      (req_payload),
      .background_color (background_color_ff),
      .job_push         (job_push),
      .job_full         (job_full),
      .job_data         (job_in_data)
   );

   // Decouple the front end from the pixel walk.
   pnrf_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .full      (job_full),
      .push_data (job_in_data),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_head)
   );

   // Walk the jobs over the frame store and post one response per request.
   pnrf_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_empty   (job_empty),
      .job_pop     (job_pop),
      .job_head    (job_head),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule
